[src/assert_macros.svh]
// Assertion macros for the RTL of the glyph blitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define GBPW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

`define GBPW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define GBPW_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define GBPW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/gbpw_pkg.sv]
// Types, widths, register indexes and color packing for the glyph blitter.
package gbpw_pkg;

	localparam int GBPW_MAX_FRAME_WIDTH  = 4096;
	localparam int GBPW_MAX_FRAME_HEIGHT = 4096;
	localparam int GBPW_MAX_GLYPH_SIZE   = 64;

	localparam int GLYPH_BYTE_W = 8;
	localparam int ORIGIN_W     = 12;
	localparam int FRAME_W      = 13;
	localparam int GLYPH_REG_W  = 7;
	localparam int FMT_W        = 4;
	localparam int COLOR_W      = 32;
	localparam int ADDR_W       = 26;
	localparam int COORD_W      = 13;
	localparam int LANES        = 8;
	localparam int LANE_IDX_W   = 3;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FONT_COLOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd5;

	// {alpha, size code}; bit 2 of the format only swaps red and blue
	localparam logic [2:0] PK_RGB444  = 3'b000;
	localparam logic [2:0] PK_RGB555  = 3'b001;
	localparam logic [2:0] PK_RGB565  = 3'b010;
	localparam logic [2:0] PK_RGB888  = 3'b011;
	localparam logic [2:0] PK_A1555   = 3'b100;
	localparam logic [2:0] PK_A4444   = 3'b101;
	localparam logic [2:0] PK_A8565   = 3'b110;
	localparam logic [2:0] PK_A8888   = 3'b111;

	typedef struct packed {
		logic [GLYPH_BYTE_W-1:0] glyph_byte;
		logic [COORD_W-1:0]      col_base;
		logic                    row_ok;
		logic [ADDR_W-1:0]       base_addr;
	} blit_item_t;

	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] addr;
	} lane_t;

	typedef struct packed {
		logic pending;
	} merge_status_t;

	typedef struct packed {
		logic [COLOR_W-1:0] data;
		logic               four;
	} color_t;

	function automatic color_t pack_color(input logic [FMT_W-1:0] fmt,
		input logic [COLOR_W-1:0] c);
		logic [7:0] a;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		color_t     res;
		a = c[31:24];
		g = c[15:8];
		if (fmt[2]) begin
			r = c[7:0];
			b = c[23:16];
		end else begin
			r = c[23:16];
			b = c[7:0];
		end
		res.four = 1'b0;
		case ({fmt[3], fmt[1:0]})
			PK_RGB444: res.data = {20'd0, r[7:4], g[7:4], b[7:4]};
			PK_RGB555: res.data = {17'd0, r[7:3], g[7:3], b[7:3]};
			PK_RGB565: res.data = {16'd0, r[7:3], g[7:2], b[7:3]};
			PK_RGB888: begin
				res.data = {8'd0, r, g, b};
				res.four = 1'b1;
			end
			PK_A1555: res.data = {16'd0, a[7], r[7:3], g[7:3], b[7:3]};
			PK_A4444: res.data = {16'd0, a[7:4], r[7:4], g[7:4], b[7:4]};
			PK_A8565: begin
				res.data = {8'd0, a, r[7:3], g[7:2], b[7:3]};
				res.four = 1'b1;
			end
			PK_A8888: begin
				res.data = {a, r, g, b};
				res.four = 1'b1;
			end
			default: res.data = '0;
		endcase
		return res;
	endfunction

	function automatic logic [FRAME_W-1:0] clamp_frame(input logic [FRAME_W-1:0] v,
		input int max_v);
		logic [FRAME_W:0] lim;
		lim = (FRAME_W+1)'(max_v);
		return ({1'b0, v} > lim) ? lim[FRAME_W-1:0] : v;
	endfunction

endpackage

[src/gbpw_if.sv]
// Request channels of the glyph blitter: glyph bytes in, pixel writes out.
interface gbpw_in_if import gbpw_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [GLYPH_BYTE_W-1:0] glyph_byte;
	logic [ORIGIN_W-1:0]     origin_x;
	logic [ORIGIN_W-1:0]     origin_y;
	logic                    new_glyph;

	modport source (output valid, glyph_byte, origin_x, origin_y, new_glyph, input ready);
	modport sink (input valid, glyph_byte, origin_x, origin_y, new_glyph, output ready);
endinterface

interface gbpw_out_if import gbpw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ADDR_W-1:0]  pixel_address;
	logic [COLOR_W-1:0] pixel_data;
	logic               pixel_size;
	logic               last_write;

	modport source (output valid, pixel_address, pixel_data, pixel_size, last_write,
		input ready);
	modport sink (input valid, pixel_address, pixel_data, pixel_size, last_write,
		output ready);
endinterface

[src/glyph_blit_pixel_writer.sv]
// Top level of the glyph blitter: configuration registers, lanes and merge stage.
//
// Accepts one glyph byte per request and issues one framebuffer write per set
// pixel that lands inside the frame, left to right, with last_write marking the
// final write of each byte. The single write port sets the rate: a byte holds
// the merge stage until its last set pixel is issued, and the next byte is
// taken while the current one is still being written out. A byte passes the
// registered stages counters and coordinates, frame-width multiply and base
// address, then the merge mask and output registers. The user must write
// configuration only while no request is in flight; the block does not check it.
`include "assert_macros.svh"

module glyph_blit_pixel_writer import gbpw_pkg::*; #(
	parameter int MAX_FRAME_WIDTH  = GBPW_MAX_FRAME_WIDTH,
	parameter int MAX_FRAME_HEIGHT = GBPW_MAX_FRAME_HEIGHT,
	parameter int MAX_GLYPH_SIZE   = GBPW_MAX_GLYPH_SIZE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	gbpw_in_if.sink               glyph_in,
	gbpw_out_if.source            pixel_out
);

	logic [FRAME_W-1:0]     frame_width_q;
	logic [FRAME_W-1:0]     frame_height_q;
	logic [FMT_W-1:0]       pixel_format_q;
	logic [COLOR_W-1:0]     font_color_q;
	logic [GLYPH_REG_W-1:0] glyph_width_q;
	logic [GLYPH_REG_W-1:0] glyph_height_q;

	logic [FRAME_W-1:0] fw_c;
	logic [FRAME_W-1:0] fh_c;
	color_t             color;
	logic               item_valid;
	logic               item_ready;
	blit_item_t         item;
	lane_t [LANES-1:0]  lanes;
	merge_status_t      merge_status;
	logic               size_ok;
	logic               addr_ok;
	logic               mid_write;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FRAME_W'(4096);
			frame_height_q <= FRAME_W'(4096);
			pixel_format_q <= FMT_W'(2);
			font_color_q <= '0;
			glyph_width_q <= GLYPH_REG_W'(16);
			glyph_height_q <= GLYPH_REG_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  frame_width_q <= cfg_wdata[FRAME_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata[FRAME_W-1:0];
				REG_PIXEL_FORMAT: pixel_format_q <= cfg_wdata[FMT_W-1:0];
				REG_FONT_COLOR:   font_color_q <= cfg_wdata[COLOR_W-1:0];
				REG_GLYPH_WIDTH:  glyph_width_q <= cfg_wdata[GLYPH_REG_W-1:0];
				REG_GLYPH_HEIGHT: glyph_height_q <= cfg_wdata[GLYPH_REG_W-1:0];
				default: ;
			endcase
		end
	end

	assign fw_c = clamp_frame(frame_width_q, MAX_FRAME_WIDTH);
	assign fh_c = clamp_frame(frame_height_q, MAX_FRAME_HEIGHT);
	assign color = pack_color(pixel_format_q, font_color_q);

	gbpw_frontend #(
		.MAX_GLYPH_SIZE(MAX_GLYPH_SIZE)
	) u_frontend (
		.clk(clk),
		.arst_n(arst_n),
		.glyph_in(glyph_in),
		.frame_width(fw_c),
		.frame_height(fh_c),
		.glyph_width(glyph_width_q),
		.glyph_height(glyph_height_q),
		.item_valid(item_valid),
		.item(item),
		.item_ready(item_ready)
	);

	for (genvar j = 0; j < LANES; j++) begin : g_lane
		gbpw_lane #(
			.LANE(j)
		) u_lane (
			.item(item),
			.frame_width(fw_c),
			.four(color.four),
			.result(lanes[j])
		);
	end

	gbpw_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.lanes(lanes),
		.pixel_data(color.data),
		.four(color.four),
		.pixel_out(pixel_out),
		.status(merge_status)
	);

	assign size_ok = pixel_out.pixel_size
		== ((pixel_format_q[1:0] == 2'b11) || (pixel_format_q[3] && pixel_format_q[1]));
	assign addr_ok = pixel_out.pixel_size ? (pixel_out.pixel_address[1:0] == 2'b00)
		: (pixel_out.pixel_address[0] == 1'b0);
	assign mid_write = pixel_out.valid && !pixel_out.last_write;

	`GBPW_ASSERT_IMPLIES(a_size_matches_format, clk, arst_n, pixel_out.valid, size_ok)
	`GBPW_ASSERT_IMPLIES(a_addr_aligned, clk, arst_n, pixel_out.valid, addr_ok)
	`GBPW_ASSERT_IMPLIES(a_more_pending, clk, arst_n, mid_write, merge_status.pending)
	`GBPW_ASSERT_NEXT(a_byte_drains, clk, arst_n, mid_write && pixel_out.ready, pixel_out.valid)

endmodule

[src/gbpw_frontend.sv]
// Glyph position counters and the address pipeline that feeds the pixel lanes.
module gbpw_frontend import gbpw_pkg::*; #(
	parameter int MAX_GLYPH_SIZE = GBPW_MAX_GLYPH_SIZE
) (
	input  logic               clk,
	input  logic               arst_n,
	gbpw_in_if.sink            glyph_in,
	input  logic [FRAME_W-1:0] frame_width,
	input  logic [FRAME_W-1:0] frame_height,
	input  logic [GLYPH_REG_W-1:0] glyph_width,
	input  logic [GLYPH_REG_W-1:0] glyph_height,
	output logic               item_valid,
	output blit_item_t         item,
	input  logic               item_ready
);

	localparam int GSZ_W = $clog2(MAX_GLYPH_SIZE + 1);
	localparam int GC_W  = (GSZ_W > GLYPH_REG_W) ? GSZ_W : GLYPH_REG_W;
	localparam int ROW_W = $clog2(MAX_GLYPH_SIZE);
	localparam int BIR_W = (MAX_GLYPH_SIZE > 8) ? $clog2((MAX_GLYPH_SIZE + 7) / 8) : 1;
	localparam logic [GC_W-1:0] GMAX = GC_W'(MAX_GLYPH_SIZE);

	logic [GC_W-1:0]  gw_ext;
	logic [GC_W-1:0]  gh_ext;
	logic [GC_W-1:0]  gw_c;
	logic [GC_W-1:0]  gh_c;
	logic [GC_W:0]    bpr;
	logic [GC_W:0]    byte_eff;
	logic [GC_W:0]    row_eff;
	logic [GC_W:0]    byte_nx;
	logic [GC_W:0]    row_nx;
	logic [ROW_W-1:0] row_q;
	logic [BIR_W-1:0] byte_q;
	logic             accept;
	logic             adv1;
	logic             adv2;
	logic             adv3;
	logic             v_s1;
	logic             v_s2;
	logic             v_s3;

	logic [GLYPH_BYTE_W-1:0] byte_s1;
	logic [COORD_W-1:0]      colb_s1;
	logic [COORD_W-1:0]      row_s1;
	logic [GLYPH_BYTE_W-1:0] byte_s2;
	logic [COORD_W-1:0]      colb_s2;
	logic                    rowok_s2;
	logic [ADDR_W-1:0]       prod_s2;
	logic [FRAME_W+COORD_W-1:0] prod_full;
	blit_item_t              item_s3;

	assign gw_ext = GC_W'(glyph_width);
	assign gh_ext = GC_W'(glyph_height);
	assign gw_c = (gw_ext == '0) ? GC_W'(1) : ((gw_ext > GMAX) ? GMAX : gw_ext);
	assign gh_c = (gh_ext == '0) ? GC_W'(1) : ((gh_ext > GMAX) ? GMAX : gh_ext);
	assign bpr = ({1'b0, gw_c} + (GC_W+1)'(7)) >> 3;

	always_comb begin
		byte_eff = (GC_W+1)'(byte_q);
		row_eff = (GC_W+1)'(row_q);
		if (glyph_in.new_glyph || byte_eff >= bpr) begin
			byte_eff = '0;
		end
		if (glyph_in.new_glyph || row_eff >= {1'b0, gh_c}) begin
			row_eff = '0;
		end
		byte_nx = byte_eff + (GC_W+1)'(1);
		row_nx = row_eff + (GC_W+1)'(1);
	end

	assign adv3 = !v_s3 || item_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign glyph_in.ready = adv1;
	assign accept = glyph_in.valid && adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			row_q <= '0;
			byte_q <= '0;
		end else begin
			if (adv1) begin
				v_s1 <= accept;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (accept) begin
				if (byte_nx >= bpr) begin
					byte_q <= '0;
					if (row_nx >= {1'b0, gh_c}) begin
						row_q <= '0;
					end else begin
						row_q <= row_nx[ROW_W-1:0];
					end
				end else begin
					byte_q <= byte_nx[BIR_W-1:0];
					row_q <= row_eff[ROW_W-1:0];
				end
			end
		end
	end

	assign prod_full = frame_width * row_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			byte_s1 <= glyph_in.glyph_byte;
			colb_s1 <= COORD_W'(glyph_in.origin_x) + (COORD_W'(byte_eff) << 3);
			row_s1 <= COORD_W'(glyph_in.origin_y) + COORD_W'(row_eff);
		end
		if (adv2) begin
			byte_s2 <= byte_s1;
			colb_s2 <= colb_s1;
			rowok_s2 <= (row_s1 < frame_height);
			prod_s2 <= prod_full[ADDR_W-1:0];
		end
		if (adv3) begin
			item_s3.glyph_byte <= byte_s2;
			item_s3.col_base <= colb_s2;
			item_s3.row_ok <= rowok_s2;
			item_s3.base_addr <= prod_s2 + ADDR_W'(colb_s2);
		end
	end

	assign item_valid = v_s3;
	assign item = item_s3;

endmodule

[src/gbpw_lane.sv]
// One pixel lane: clip test and byte address for one bit of a glyph byte.
module gbpw_lane import gbpw_pkg::*; #(
	parameter int LANE = 0
) (
	input  blit_item_t         item,
	input  logic [FRAME_W-1:0] frame_width,
	input  logic               four,
	output lane_t              result
);

	logic [COORD_W-1:0] col;
	logic [ADDR_W-1:0]  sum;

	assign col = item.col_base + COORD_W'(LANE);
	assign sum = item.base_addr + ADDR_W'(LANE);
	assign result.hit = item.glyph_byte[GLYPH_BYTE_W-1-LANE] && item.row_ok
		&& (col < frame_width);
	assign result.addr = four ? {sum[ADDR_W-3:0], 2'b00} : {sum[ADDR_W-2:0], 1'b0};

endmodule

[src/gbpw_merge.sv]
// Merge stage: hold a byte's lane results, issue one write per cycle unless stalled.
module gbpw_merge import gbpw_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  lane_t [LANES-1:0]      lanes,
	input  logic [COLOR_W-1:0]     pixel_data,
	input  logic                   four,
	gbpw_out_if.source             pixel_out,
	output merge_status_t          status
);

	logic [LANES-1:0]      mask_q;
	logic [LANES-1:0]      mask_after;
	logic [LANES-1:0]      hits;
	logic [ADDR_W-1:0]     addr_q [LANES];
	logic [LANE_IDX_W-1:0] idx;
	logic                  out_free;
	logic                  pop;
	logic                  load;
	logic                  out_valid_q;
	logic [ADDR_W-1:0]     out_addr_q;
	logic [COLOR_W-1:0]    out_data_q;
	logic                  out_size_q;
	logic                  out_last_q;

	always_comb begin
		idx = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				idx = LANE_IDX_W'(i);
			end
		end
		for (int i = 0; i < LANES; i++) begin
			hits[i] = lanes[i].hit;
		end
	end

	assign out_free = !out_valid_q || pixel_out.ready;
	assign pop = out_free && (mask_q != '0);
	assign mask_after = pop ? (mask_q & (mask_q - LANES'(1))) : mask_q;
	assign item_ready = (mask_after == '0);
	assign load = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mask_q <= hits;
			end else begin
				mask_q <= mask_after;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (pixel_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < LANES; i++) begin
				addr_q[i] <= lanes[i].addr;
			end
		end
		if (pop) begin
			out_addr_q <= addr_q[idx];
			out_data_q <= pixel_data;
			out_size_q <= four;
			out_last_q <= (mask_after == '0);
		end
	end

	assign pixel_out.valid = out_valid_q;
	assign pixel_out.pixel_address = out_addr_q;
	assign pixel_out.pixel_data = out_data_q;
	assign pixel_out.pixel_size = out_size_q;
	assign pixel_out.last_write = out_last_q;
	assign status.pending = (mask_q != '0);

endmodule
